>>> rtl/jss_pkg.sv
package jss_pkg;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_BITS = 1;
   localparam int unsigned CSR_DATA_BITS  = 32;
   localparam logic [CSR_INDEX_BITS-1:0] REG_GRID_SIZE = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_THRESHOLD = 1'b1;

   localparam int unsigned GRID_BITS      = 11;
   localparam int unsigned THRESHOLD_BITS = 32;
   localparam int unsigned RESET_SIDE     = 256;
   localparam int unsigned MIN_SIDE       = 3;
   localparam logic [THRESHOLD_BITS-1:0] RESET_THRESHOLD = 32'd17;

   // Result queue depth and the slack that one item may need in it.
   localparam int unsigned RSP_DEPTH     = 8;
   localparam int unsigned MAX_PER_ITEM  = 2;

   typedef struct packed {
      logic emit_mid;     // emits the updated cell of the row above
      logic emit_cur;     // last row: the input passes itself through
      logic interior;     // the emitted cell takes the stencil value
      logic sweep_end;    // second result of the last cell of the grid
      logic restart;      // position was outside the grid, clear the maximum first
   } ctl_type;

endpackage

>>> rtl/jacobi_stencil_sweep_top.sv
// Throughput: one input beat per cycle while the result credits keep req_tready high; in
// the last grid row each input makes two result beats, so that row is limited by the
// single result beat per cycle. Each accepted beat reads the middle-row memory twice and
// the upper-row memory once, registered, and writes each memory once.
// Reset is synchronous and active high; it clears positions, the running maximum, the
// result queue and the registers to their defaults. The row memories need no clearing.
module jacobi_stencil_sweep_top #(
   parameter int unsigned MAX_SIDE   = 1024,
   parameter int unsigned VALUE_BITS = 32
) (
   input  logic clock,
   input  logic reset,
   // req_tdata fields from bit 0: cell_value
   input  logic                                        req_tvalid,
   output logic                                        req_tready,
   input  logic [((VALUE_BITS+7)/8)*8-1:0]             req_tdata,
   // rsp_tdata fields from bit 0: new_value, max_change, converged
   output logic                                        rsp_tvalid,
   input  logic                                        rsp_tready,
   output logic [((2*VALUE_BITS+1+7)/8)*8-1:0]         rsp_tdata,
   output logic                                        rsp_tlast,
   input  logic                                        csr_valid,
   output logic                                        csr_ready,
   input  logic [jss_pkg::CSR_INDEX_BITS-1:0]          csr_index,
   input  logic [jss_pkg::CSR_DATA_BITS-1:0]           csr_data
);
   import jss_pkg::*;

   localparam int unsigned V     = VALUE_BITS;
   localparam int unsigned OW    = ((2*VALUE_BITS+1+7)/8)*8;
   localparam int unsigned AW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
   localparam int unsigned SW    = $clog2(MAX_SIDE+1);
   localparam int unsigned GCW   = (GRID_BITS > SW) ? GRID_BITS : SW;
   localparam int unsigned CW    = (V > THRESHOLD_BITS) ? V : THRESHOLD_BITS;
   localparam int unsigned PW    = $clog2(RSP_DEPTH);
   localparam int unsigned QW    = $clog2(RSP_DEPTH+1);
   localparam int unsigned RST_SIDE = (RESET_SIDE > MAX_SIDE) ? MAX_SIDE : RESET_SIDE;

   // ---------------- configuration ----------------
   logic [SW-1:0]             side_ff, side_in;
   logic [THRESHOLD_BITS-1:0] thr_ff;
   logic [GCW-1:0]            grid_ext;

   assign csr_ready = 1'b1;
   assign grid_ext  = GCW'(csr_data[GRID_BITS-1:0]);

   always_comb begin
      if (grid_ext < GCW'(MIN_SIDE)) begin
         side_in = SW'(MIN_SIDE);
      end else if (grid_ext > GCW'(MAX_SIDE)) begin
         side_in = SW'(MAX_SIDE);
      end else begin
         side_in = grid_ext[SW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= SW'(RST_SIDE);
         thr_ff  <= RESET_THRESHOLD;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_GRID_SIZE: side_ff <= side_in;
            REG_THRESHOLD: thr_ff  <= csr_data[THRESHOLD_BITS-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- position and accept ----------------
   logic [AW-1:0] row_ff, col_ff, row_in, col_in;
   logic [AW-1:0] cur_row, cur_col, addr_next1;
   logic          restart, last_row, last_col, accept;
   logic [1:0]    nres;
   ctl_type       acc_ctl;
   logic [V-1:0]  cell_value;

   assign cell_value = req_tdata[V-1:0];
   assign accept  = req_tvalid && req_tready;
   assign restart = ({1'b0, row_ff} >= (AW+1)'(side_ff)) ||
                    ({1'b0, col_ff} >= (AW+1)'(side_ff));
   assign cur_row  = restart ? '0 : row_ff;
   assign cur_col  = restart ? '0 : col_ff;
   assign last_row = ((AW+1)'(cur_row) == (AW+1)'(side_ff - SW'(1)));
   assign last_col = ((AW+1)'(cur_col) == (AW+1)'(side_ff - SW'(1)));

   always_comb begin
      acc_ctl.emit_mid  = (cur_row != '0);
      acc_ctl.emit_cur  = last_row;
      // The emitted cell sits one row up, so the last input row still yields interior cells.
      acc_ctl.interior  = (cur_row > AW'(1)) && (cur_col != '0) && !last_col;
      acc_ctl.sweep_end = last_row && last_col;
      acc_ctl.restart   = restart;
      nres = {1'b0, acc_ctl.emit_mid} + {1'b0, acc_ctl.emit_cur};
      if (last_col) begin
         col_in = '0;
         row_in = last_row ? '0 : cur_row + AW'(1);
      end else begin
         col_in = cur_col + AW'(1);
         row_in = cur_row;
      end
      // The neighbor to the right of the next cell; unused past the grid edge.
      addr_next1 = (col_in == AW'(MAX_SIDE-1)) ? '0 : col_in + AW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (accept) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // ---------------- row memories ----------------
   // The reads for the next cell are issued with each accepted beat, so the window
   // below always holds middle[c], upper[c] and middle[c+1] for the stored position.
   // Writes go to the current column, never to the two columns being read.
   logic [V-1:0] mid_mem [MAX_SIDE];
   logic [V-1:0] up_mem  [MAX_SIDE];
   logic [V-1:0] win_mid_ff, win_right_ff, win_up_ff, prev_mid_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         win_mid_ff      <= mid_mem[col_in];
         win_right_ff    <= mid_mem[addr_next1];
         win_up_ff       <= up_mem[col_in];
         mid_mem[cur_col] <= cell_value;
         up_mem[cur_col]  <= win_mid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_mid_ff <= '0;
      end else if (accept) begin
         prev_mid_ff <= win_mid_ff;
      end
   end

   // ---------------- compute pipeline ----------------
   logic               s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff;
   ctl_type            s1_ctl_ff, s2_ctl_ff, s3_ctl_ff, s4_ctl_ff;
   logic [V-1:0]       s1_up_ff, s1_cur_ff, s1_left_ff, s1_right_ff, s1_mid_ff;
   logic [V-1:0]       s2_cur_ff, s2_mid_ff, s3_cur_ff, s3_mid_ff, s4_cur_ff;
   logic signed [V:0]  s2_pair_a_ff, s2_pair_b_ff;
   logic signed [V+1:0] quad_sum;
   logic [V-1:0]       s3_new_ff, s4_val_ff, s4_diff_ff;
   logic signed [V:0]  diff_fwd, diff_rev;

   assign quad_sum = {s2_pair_a_ff[V], s2_pair_a_ff} + {s2_pair_b_ff[V], s2_pair_b_ff};
   assign diff_fwd = $signed({s3_new_ff[V-1], s3_new_ff}) - $signed({s3_mid_ff[V-1], s3_mid_ff});
   assign diff_rev = $signed({s3_mid_ff[V-1], s3_mid_ff}) - $signed({s3_new_ff[V-1], s3_new_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= accept;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_ctl_ff   <= acc_ctl;
      s1_up_ff    <= win_up_ff;
      s1_cur_ff   <= cell_value;
      s1_left_ff  <= prev_mid_ff;
      s1_right_ff <= win_right_ff;
      s1_mid_ff   <= win_mid_ff;

      s2_ctl_ff    <= s1_ctl_ff;
      s2_cur_ff    <= s1_cur_ff;
      s2_mid_ff    <= s1_mid_ff;
      s2_pair_a_ff <= $signed({s1_up_ff[V-1], s1_up_ff}) + $signed({s1_cur_ff[V-1], s1_cur_ff});
      s2_pair_b_ff <= $signed({s1_left_ff[V-1], s1_left_ff}) +
                      $signed({s1_right_ff[V-1], s1_right_ff});

      // Floor of the quarter: arithmetic shift of the exact sum.
      s3_ctl_ff <= s2_ctl_ff;
      s3_cur_ff <= s2_cur_ff;
      s3_mid_ff <= s2_mid_ff;
      s3_new_ff <= quad_sum[V+1:2];

      s4_ctl_ff  <= s3_ctl_ff;
      s4_cur_ff  <= s3_cur_ff;
      s4_val_ff  <= s3_ctl_ff.interior ? s3_new_ff : s3_mid_ff;
      s4_diff_ff <= diff_fwd[V] ? diff_rev[V-1:0] : diff_fwd[V-1:0];
   end

   // ---------------- running maximum ----------------
   // The absolute difference of two values of V bits always fits in V bits unsigned.
   logic [V-1:0] max_ff, max_in, max_base;
   logic         conv;

   assign max_base = s4_ctl_ff.restart ? '0 : max_ff;
   assign conv     = (CW'(max_ff) <= CW'(thr_ff));

   always_comb begin
      max_in = max_ff;
      if (s4_vld_ff) begin
         max_in = max_base;
         if (s4_ctl_ff.interior && (s4_diff_ff > max_base)) begin
            max_in = s4_diff_ff;
         end
         if (s4_ctl_ff.sweep_end) begin
            max_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= '0;
      end else begin
         max_ff <= max_in;
      end
   end

   // ---------------- result queue ----------------
   logic [V-1:0]  q_val_ff  [RSP_DEPTH];
   logic [V-1:0]  q_max_ff  [RSP_DEPTH];
   logic          q_conv_ff [RSP_DEPTH];
   logic          q_last_ff [RSP_DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff, wr_ptr_b;
   logic [QW-1:0] fill_ff, fill_in, credit_ff, credit_in;
   logic          push_a, push_b, pop;
   logic [1:0]    npush;

   assign push_a   = s4_vld_ff && s4_ctl_ff.emit_mid;
   assign push_b   = s4_vld_ff && s4_ctl_ff.emit_cur;
   assign npush    = {1'b0, push_a} + {1'b0, push_b};
   assign wr_ptr_b = wr_ptr_ff + PW'(push_a);
   assign pop      = rsp_tvalid && rsp_tready;

   // Credits count results of accepted beats that are not yet delivered, so the
   // pipeline never has to stall.
   assign req_tready = (credit_ff <= QW'(RSP_DEPTH - MAX_PER_ITEM));
   assign credit_in  = credit_ff + (accept ? QW'(nres) : '0) - QW'(pop);
   assign fill_in    = fill_ff + QW'(npush) - QW'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
         credit_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + PW'(npush);
         rd_ptr_ff <= rd_ptr_ff + PW'(pop);
         fill_ff   <= fill_in;
         credit_ff <= credit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_a) begin
         q_val_ff[wr_ptr_ff]  <= s4_val_ff;
         q_max_ff[wr_ptr_ff]  <= '0;
         q_conv_ff[wr_ptr_ff] <= 1'b0;
         q_last_ff[wr_ptr_ff] <= 1'b0;
      end
      if (push_b) begin
         q_val_ff[wr_ptr_b]  <= s4_cur_ff;
         q_max_ff[wr_ptr_b]  <= s4_ctl_ff.sweep_end ? max_ff : '0;
         q_conv_ff[wr_ptr_b] <= s4_ctl_ff.sweep_end && conv;
         q_last_ff[wr_ptr_b] <= s4_ctl_ff.sweep_end;
      end
   end

   assign rsp_tvalid = (fill_ff != '0);
   assign rsp_tdata  = OW'({q_conv_ff[rd_ptr_ff], q_max_ff[rd_ptr_ff], q_val_ff[rd_ptr_ff]});
   assign rsp_tlast  = q_last_ff[rd_ptr_ff];

endmodule

>>> rtl/jss_checker.sv
module jss_checker #(
   parameter int unsigned VALUE_BITS = 32
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [((2*VALUE_BITS+1+7)/8)*8-1:0] rsp_tdata,
   input logic                                rsp_tlast
);

   // A result beat held back by the sink stays offered and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   // The queue comes out of reset empty and with room for input.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not empty and ready after reset");

   // Only the last beat of a sweep carries the maximum and the convergence flag.
   a_side_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> (rsp_tdata[2*VALUE_BITS:VALUE_BITS] == '0))
      else $error("summary fields set on a beat that does not end the sweep");

   // A beat that reports convergence is the last beat of the sweep.
   a_conv_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2*VALUE_BITS] |-> rsp_tlast)
      else $error("convergence flag outside the last beat");

endmodule

bind jacobi_stencil_sweep_top jss_checker #(.VALUE_BITS(VALUE_BITS)) u_jss_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

>>> dv/tb_jacobi_stencil_sweep_top.sv
module tb_jacobi_stencil_sweep_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned MAX_SIDE      = 1024;
   localparam int unsigned VALUE_BITS    = 32;
   localparam int unsigned SETTLE_CYCLES = 12;
   localparam int unsigned STALL_LIMIT   = 5000;
   localparam int unsigned RANDOM_CELLS  = 550;

   typedef struct packed {
      logic [31:0] new_value;
      logic [31:0] max_change;
      logic        converged;
      logic        final_res;
   } cell_update_type;

   logic clock;
   logic reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [jss_pkg::CSR_INDEX_BITS-1:0] csr_index = jss_pkg::REG_GRID_SIZE;
   logic [jss_pkg::CSR_DATA_BITS-1:0]  csr_data  = '0;

   jacobi_stencil_sweep_top #(
      .MAX_SIDE   (MAX_SIDE),
      .VALUE_BITS (VALUE_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Shadow of the block: registers, row stores, raster position and sweep maximum.
   logic [10:0] grid_reg      = 11'(jss_pkg::RESET_SIDE);
   logic [31:0] threshold_reg = jss_pkg::RESET_THRESHOLD;
   bit   [31:0] two_up_row [MAX_SIDE];
   bit   [31:0] one_up_row [MAX_SIDE];
   bit   [31:0] left_center = '0;
   int unsigned cur_row     = 0;
   int unsigned cur_col     = 0;
   logic [31:0] sweep_max   = '0;

   logic [31:0]     cell_q[$];
   cell_update_type pending_updates[$];
   int unsigned     send_idle_pct = 9;
   int unsigned     recv_idle_pct = 65;
   int unsigned     fail_count    = 0;
   int unsigned     stall_cycles  = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int unsigned side_in_use();
      if (grid_reg < 11'(jss_pkg::MIN_SIDE)) begin
         return jss_pkg::MIN_SIDE;
      end
      if (grid_reg > 11'(MAX_SIDE)) begin
         return MAX_SIDE;
      end
      return 32'(grid_reg);
   endfunction

   function automatic void expect_update(input logic [31:0] value, input bit last_of_sweep);
      cell_update_type upd;
      upd.new_value  = value;
      upd.max_change = last_of_sweep ? sweep_max : '0;
      upd.converged  = last_of_sweep && (sweep_max <= threshold_reg);
      upd.final_res  = last_of_sweep;
      pending_updates.push_back(upd);
   endfunction

   // Updates the shadow for one accepted input and queues the updates it produces.
   function automatic void sweep_cell(input logic [31:0] incoming);
      int unsigned        n;
      int unsigned        r;
      int unsigned        c;
      logic [31:0]        old_mid;
      logic [31:0]        old_up;
      logic [31:0]        out_value;
      logic signed [33:0] stencil_sum;
      logic signed [32:0] delta;
      logic [32:0]        magnitude;
      bit                 interior;
      n = side_in_use();
      if (cur_row >= n || cur_col >= n) begin
         cur_row   = 0;
         cur_col   = 0;
         sweep_max = '0;
      end
      r       = cur_row;
      c       = cur_col;
      old_mid = one_up_row[c];
      old_up  = two_up_row[c];
      if (r >= 1) begin
         out_value = old_mid;
         interior  = (r >= 2) && (r <= n - 1) && (c >= 1) && (c <= n - 2);
         if (interior) begin
            stencil_sum = 34'($signed(old_up)) + 34'($signed(incoming))
                        + 34'($signed(left_center)) + 34'($signed(one_up_row[c+1]));
            out_value   = stencil_sum[33:2];
            delta       = $signed({out_value[31], out_value}) - $signed({old_mid[31], old_mid});
            magnitude   = delta[32] ? 33'(-delta) : 33'(delta);
            if (magnitude > 33'h0_FFFF_FFFF) begin
               magnitude = 33'h0_FFFF_FFFF;
            end
            if (magnitude[31:0] > sweep_max) begin
               sweep_max = magnitude[31:0];
            end
         end
         expect_update(out_value, 1'b0);
         if (r == n - 1) begin
            expect_update(incoming, c == n - 1);
         end
      end
      two_up_row[c] = old_mid;
      one_up_row[c] = incoming;
      left_center   = old_mid;
      c++;
      if (c >= n) begin
         c = 0;
         r++;
         if (r >= n) begin
            r         = 0;
            sweep_max = '0;
         end
      end
      cur_row = r;
      cur_col = c;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            sweep_cell(req_tdata);
         end
         if (!req_tvalid || req_tready) begin
            if (cell_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata  <= cell_q.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_updates
      cell_update_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_updates.size() == 0) begin
               $error("unexpected result beat: new_value %h", rsp_tdata[31:0]);
               fail_count++;
            end else begin
               want = pending_updates.pop_front();
               if (rsp_tdata[31:0] !== want.new_value) begin
                  $error("new_value: expected %h, actual %h", want.new_value, rsp_tdata[31:0]);
                  fail_count++;
               end
               if (rsp_tdata[63:32] !== want.max_change) begin
                  $error("max_change: expected %h, actual %h", want.max_change,
                         rsp_tdata[63:32]);
                  fail_count++;
               end
               if (rsp_tdata[64] !== want.converged) begin
                  $error("converged: expected %b, actual %b", want.converged, rsp_tdata[64]);
                  fail_count++;
               end
               if (rsp_tlast !== want.final_res) begin
                  $error("final_res: expected %b, actual %b", want.final_res, rsp_tlast);
                  fail_count++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic write_reg(input logic [jss_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == jss_pkg::REG_GRID_SIZE) begin
         grid_reg = value[10:0];
      end else begin
         threshold_reg = value;
      end
   endtask

   // The upper data bits are ignored by the grid register, so fill them with noise.
   task automatic write_side(input logic [10:0] side);
      write_reg(jss_pkg::REG_GRID_SIZE, ($urandom & 32'hFFFF_F800) | 32'(side));
   endtask

   // Waits until every input is taken and every update has come back, then lets
   // the pipeline settle, since row-0 inputs produce nothing to wait on.
   task automatic drain();
      while (cell_q.size() != 0 || req_tvalid || pending_updates.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // A smooth grid keeps the changes small, so thresholds near them are meaningful.
   task automatic queue_cells(input int unsigned count, input bit smooth,
                              input logic [31:0] base);
      for (int unsigned i = 0; i < count; i++) begin
         if (smooth) begin
            cell_q.push_back(base + 32'($urandom_range(63)) - 32'd32);
         end else begin
            cell_q.push_back($urandom);
         end
      end
   endtask

   initial begin
      int unsigned random_cells;
      int unsigned n;
      int unsigned k;
      bit          big_done;
      random_cells = 0;
      big_done     = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Center at the positive extreme, all neighbors at the negative extreme:
      // the largest possible change, equal to the largest threshold.
      write_reg(jss_pkg::REG_THRESHOLD, 32'hFFFF_FFFF);
      write_reg(jss_pkg::REG_GRID_SIZE, 32'd0);
      cell_q = '{32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0000};
      drain();

      // Leave a 4x4 sweep in row 1 at column 3, then shrink the grid so the
      // position falls outside it and the next input restarts the sweep.
      write_reg(jss_pkg::REG_THRESHOLD, 32'd0);
      write_reg(jss_pkg::REG_GRID_SIZE, 32'd4);
      queue_cells(7, 1'b0, '0);
      drain();
      write_reg(jss_pkg::REG_GRID_SIZE, 32'd3);
      // A lone negative neighbor must round toward minus infinity.
      cell_q = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
                 32'h0000_0000, 32'h0000_0005, 32'h0000_0000,
                 32'h0000_0000, 32'h0000_0000, 32'h0000_0000};
      drain();

      while (random_cells < RANDOM_CELLS) begin
         if (random_cells >= 2 * RANDOM_CELLS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else if (random_cells >= RANDOM_CELLS / 3) begin
            send_idle_pct = 65;
            recv_idle_pct = 9;
         end

         if (!big_done && random_cells >= 2 * RANDOM_CELLS / 3) begin
            // An oversized value clamps to the largest side, so a short run of
            // row 0 stays inside the grid until the shrink below restarts it.
            big_done = 1'b1;
            drain();
            write_side(11'd2047);
            queue_cells(12, 1'b0, '0);
            drain();
            write_side(11'($urandom_range(3)));
            queue_cells(9, 1'b0, '0);
            random_cells += 21;
         end else if ($urandom_range(99) < 15) begin
            // Broken sweep: stop with the column at 3 or beyond, then shrink to 3.
            drain();
            if (side_in_use() < 4) begin
               write_side(11'($urandom_range(5, 10)));
            end
            n = side_in_use();
            k = $urandom_range(n - 1) * n + $urandom_range(3, n - 1);
            queue_cells(k, 1'b0, '0);
            drain();
            write_side(11'($urandom_range(3)));
            queue_cells(9, $urandom_range(1), $urandom);
            random_cells += k + 9;
         end else begin
            if ($urandom_range(1) == 0) begin
               drain();
               if ($urandom_range(4) == 0) begin
                  write_side(11'($urandom_range(9, 20)));
               end else begin
                  write_side(11'($urandom_range(2, 8)));
               end
            end
            if ($urandom_range(3) == 0) begin
               drain();
               case ($urandom_range(3))
                  0: write_reg(jss_pkg::REG_THRESHOLD, 32'd0);
                  1: write_reg(jss_pkg::REG_THRESHOLD, 32'hFFFF_FFFF);
                  2: write_reg(jss_pkg::REG_THRESHOLD, $urandom);
                  default: write_reg(jss_pkg::REG_THRESHOLD, 32'($urandom_range(64)));
               endcase
            end
            n = side_in_use();
            queue_cells(n * n, $urandom_range(1), $urandom);
            random_cells += n * n;
            if ($urandom_range(9) == 0) begin
               drain();
            end
         end
      end

      drain();
      if (fail_count == 0 && pending_updates.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
